@@ rtl/vurp_pkg.sv @@
package vurp_pkg;

    localparam int PATTERN_BYTES = 8192;
    localparam int NAME_BYTES    = 2048;
    localparam int OAM_BYTES     = 256;
    localparam int PAL_BYTES     = 32;

    localparam int PAT_AW  = $clog2(PATTERN_BYTES);
    localparam int NAME_AW = $clog2(NAME_BYTES);
    localparam int OAM_AW  = $clog2(OAM_BYTES);
    localparam int PAL_AW  = $clog2(PAL_BYTES);
    localparam int VA_W    = 14;

    localparam logic [PAT_AW-1:0] CLR_LAST = PAT_AW'(PATTERN_BYTES - 1);

    localparam logic [2:0] REQ_READ     = 3'd0;
    localparam logic [2:0] REQ_WRITE    = 3'd1;
    localparam logic [2:0] REQ_DMA      = 3'd2;
    localparam logic [2:0] REQ_VBL_BEG  = 3'd3;
    localparam logic [2:0] REQ_VBL_END  = 3'd4;

    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    localparam logic [5:0] PAL_PAGE = 6'h3f;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef enum logic [1:0] {
        RGN_PAT,
        RGN_NAME,
        RGN_PAL
    } t_region;

    typedef struct packed {
        logic              clr;
        logic [PAT_AW-1:0] clr_idx;
        logic              rd;
        logic              wr;
        logic [VA_W-1:0]   addr;
        logic              mirror;
        logic [7:0]        wdata;
    } t_vmem_req;

    function automatic t_region region_of(input logic [VA_W-1:0] a);
        t_region r;
        if (!a[13]) begin
            r = RGN_PAT;
        end else if (a[13:8] == PAL_PAGE) begin
            r = RGN_PAL;
        end else begin
            r = RGN_NAME;
        end
        return r;
    endfunction

    function automatic logic [NAME_AW-1:0] name_index(input logic [VA_W-1:0] a,
                                                      input logic mirror);
        logic [NAME_AW-1:0] idx;
        if (mirror) begin
            idx = a[10:0];
        end else begin
            idx = {a[11], a[9:0]};
        end
        return idx;
    endfunction

    function automatic logic [PAL_AW-1:0] pal_index(input logic [VA_W-1:0] a);
        logic [PAL_AW-1:0] idx;
        idx = a[4:0];
        if (idx[4] && (idx[1:0] == 2'b00)) begin
            idx[4] = 1'b0;
        end
        return idx;
    endfunction

endpackage

@@ rtl/vurp_ram.sv @@
module vurp_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/vurp_vmem.sv @@
module vurp_vmem (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vurp_pkg::t_vmem_req i_req,
    output logic [7:0]          o_rdata
);
    import vurp_pkg::*;

    t_region            rgn;
    t_region            r_rgn;
    logic [NAME_AW-1:0] name_idx;
    logic [PAL_AW-1:0]  pal_idx;
    logic               pat_we, name_we, pal_we;
    logic [PAT_AW-1:0]  pat_wa;
    logic [NAME_AW-1:0] name_wa;
    logic [PAL_AW-1:0]  pal_wa;
    logic [7:0]         wdata;
    logic [7:0]         pat_rd, name_rd, pal_rd;

    always_comb begin
        rgn      = region_of(i_req.addr);
        name_idx = name_index(i_req.addr, i_req.mirror);
        pal_idx  = pal_index(i_req.addr);
        if (i_req.clr) begin
            pat_we  = 1'b1;
            name_we = 1'b1;
            pal_we  = 1'b1;
            pat_wa  = i_req.clr_idx;
            name_wa = i_req.clr_idx[NAME_AW-1:0];
            pal_wa  = i_req.clr_idx[PAL_AW-1:0];
            wdata   = '0;
        end else begin
            pat_we  = i_req.wr && (rgn == RGN_PAT);
            name_we = i_req.wr && (rgn == RGN_NAME);
            pal_we  = i_req.wr && (rgn == RGN_PAL);
            pat_wa  = i_req.addr[PAT_AW-1:0];
            name_wa = name_idx;
            pal_wa  = pal_idx;
            wdata   = i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rgn <= RGN_PAT;
        end else if (i_req.rd) begin
            r_rgn <= rgn;
        end
    end

    vurp_ram #(.DEPTH(PATTERN_BYTES), .WIDTH(8)) u_pat (
        .i_clk   (i_clk),
        .i_we    (pat_we),
        .i_waddr (pat_wa),
        .i_wdata (wdata),
        .i_re    (i_req.rd && (rgn == RGN_PAT)),
        .i_raddr (i_req.addr[PAT_AW-1:0]),
        .o_rdata (pat_rd)
    );

    vurp_ram #(.DEPTH(NAME_BYTES), .WIDTH(8)) u_name (
        .i_clk   (i_clk),
        .i_we    (name_we),
        .i_waddr (name_wa),
        .i_wdata (wdata),
        .i_re    (i_req.rd && (rgn == RGN_NAME)),
        .i_raddr (name_idx),
        .o_rdata (name_rd)
    );

    vurp_ram #(.DEPTH(PAL_BYTES), .WIDTH(8)) u_pal (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (pal_wa),
        .i_wdata (wdata),
        .i_re    (i_req.rd && (rgn == RGN_PAL)),
        .i_raddr (pal_idx),
        .o_rdata (pal_rd)
    );

    always_comb begin
        case (r_rgn)
            RGN_PAT:  o_rdata = pat_rd;
            RGN_NAME: o_rdata = name_rd;
            RGN_PAL:  o_rdata = pal_rd;
            default:  o_rdata = pat_rd;
        endcase
    end

endmodule

@@ rtl/video_unit_register_port.sv @@
// A beat is accepted in the idle state; its result is written to the output register in the
// execute state. No new beat is accepted before the current one has executed; the accept
// cycle reads the memories, the execute cycle modifies and writes back.
// A result waiting downstream stalls the execute cycle; the next beat is then not accepted.
// Reset is synchronous and active low. After reset a clearing pass zeroes all memories
// while no beat is accepted; configuration writes are taken throughout.
module video_unit_register_port (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] write_data
    input  logic [5:0] i_s_axis_tuser,   // [2:0] req_type, [5:3] reg_index
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] read_data
    output logic       o_m_axis_tuser    // [0] nmi_level
);
    import vurp_pkg::*;

    t_state            r_state, n_state;
    logic [PAT_AW-1:0] r_clr_cnt, n_clr_cnt;
    logic              r_mirror;
    logic [2:0]        r_req, r_reg;
    logic [7:0]        r_wdata;
    logic [7:0]        r_ctrl, n_ctrl;
    logic              r_vblank, n_vblank;
    logic [7:0]        r_oam_ptr, n_oam_ptr;
    logic [14:0]       r_cur, n_cur;
    logic [14:0]       r_tmp, n_tmp;
    logic [2:0]        r_fine_x, n_fine_x;
    logic              r_toggle, n_toggle;
    logic [7:0]        r_rbuf, n_rbuf;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_data, n_out_data;
    logic              r_out_nmi, n_out_nmi;

    logic              accept;
    logic              done;
    logic              oam_we;
    logic              vid_wr;
    logic              advance;
    logic [VA_W-1:0]   inc_addr;
    logic [7:0]        oam_rdata;
    logic [7:0]        vid_rdata;
    t_vmem_req         vreq;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_ctrl      = r_ctrl;
        n_vblank    = r_vblank;
        n_oam_ptr   = r_oam_ptr;
        n_cur       = r_cur;
        n_tmp       = r_tmp;
        n_fine_x    = r_fine_x;
        n_toggle    = r_toggle;
        n_rbuf      = r_rbuf;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        n_out_nmi   = r_out_nmi;
        done        = 1'b0;
        oam_we      = 1'b0;
        vid_wr      = 1'b0;
        advance     = 1'b0;
        inc_addr    = r_cur[VA_W-1:0] + (r_ctrl[2] ? VA_W'(32) : VA_W'(1));

        case (r_state)
            ST_CLEAR: begin
                n_clr_cnt = r_clr_cnt + PAT_AW'(1);
                if (r_clr_cnt == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    done       = 1'b1;
                    n_state    = ST_IDLE;
                    n_out_data = '0;
                    case (r_req)
                        REQ_READ: begin
                            case (r_reg)
                                REG_STATUS: begin
                                    n_out_data = {r_vblank, 2'b00, r_rbuf[4:0]};
                                    n_vblank   = 1'b0;
                                    n_toggle   = 1'b0;
                                end
                                REG_OAM_DATA: begin
                                    n_out_data = oam_rdata;
                                end
                                REG_DATA: begin
                                    n_rbuf     = vid_rdata;
                                    n_out_data = (r_cur[13:8] == PAL_PAGE) ? vid_rdata
                                                                            : r_rbuf;
                                    advance    = 1'b1;
                                end
                                default: begin
                                end
                            endcase
                        end
                        REQ_WRITE: begin
                            case (r_reg)
                                REG_CTRL: begin
                                    n_ctrl        = r_wdata;
                                    n_tmp[11:10]  = r_wdata[1:0];
                                end
                                REG_OAM_ADDR: begin
                                    n_oam_ptr = r_wdata;
                                end
                                REG_OAM_DATA: begin
                                    oam_we    = 1'b1;
                                    n_oam_ptr = r_oam_ptr + 8'd1;
                                end
                                REG_SCROLL: begin
                                    if (!r_toggle) begin
                                        n_fine_x   = r_wdata[2:0];
                                        n_tmp[4:0] = r_wdata[7:3];
                                        n_toggle   = 1'b1;
                                    end else begin
                                        n_tmp[14:12] = r_wdata[2:0];
                                        n_tmp[9:5]   = r_wdata[7:3];
                                        n_toggle     = 1'b0;
                                    end
                                end
                                REG_ADDR: begin
                                    if (!r_toggle) begin
                                        n_tmp    = {1'b0, r_wdata[5:0], r_tmp[7:0]};
                                        n_toggle = 1'b1;
                                    end else begin
                                        n_tmp    = {r_tmp[14:8], r_wdata};
                                        n_cur    = {r_tmp[14:8], r_wdata};
                                        n_toggle = 1'b0;
                                    end
                                end
                                REG_DATA: begin
                                    vid_wr  = 1'b1;
                                    advance = 1'b1;
                                end
                                default: begin
                                end
                            endcase
                        end
                        REQ_DMA: begin
                            oam_we    = 1'b1;
                            n_oam_ptr = r_oam_ptr + 8'd1;
                        end
                        REQ_VBL_BEG: begin
                            n_vblank = 1'b1;
                        end
                        REQ_VBL_END: begin
                            n_vblank = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                    if (advance) begin
                        n_cur = {1'b0, inc_addr};
                    end
                    n_out_valid = 1'b1;
                    n_out_nmi   = n_vblank && n_ctrl[7];
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_mirror    <= 1'b0;
            r_ctrl      <= '0;
            r_vblank    <= 1'b0;
            r_oam_ptr   <= '0;
            r_cur       <= '0;
            r_tmp       <= '0;
            r_fine_x    <= '0;
            r_toggle    <= 1'b0;
            r_rbuf      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            if (i_cfg_we) begin
                r_mirror <= i_cfg_wdata;
            end
            r_ctrl      <= n_ctrl;
            r_vblank    <= n_vblank;
            r_oam_ptr   <= n_oam_ptr;
            r_cur       <= n_cur;
            r_tmp       <= n_tmp;
            r_fine_x    <= n_fine_x;
            r_toggle    <= n_toggle;
            r_rbuf      <= n_rbuf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= i_s_axis_tuser[2:0];
            r_reg   <= i_s_axis_tuser[5:3];
            r_wdata <= i_s_axis_tdata;
        end
        if (done) begin
            r_out_data <= n_out_data;
            r_out_nmi  <= n_out_nmi;
        end
    end

    always_comb begin
        vreq.clr     = (r_state == ST_CLEAR);
        vreq.clr_idx = r_clr_cnt;
        vreq.rd      = accept;
        vreq.wr      = vid_wr;
        vreq.addr    = r_cur[VA_W-1:0];
        vreq.mirror  = r_mirror;
        vreq.wdata   = r_wdata;
    end

    vurp_vmem u_vmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (vreq),
        .o_rdata (vid_rdata)
    );

    vurp_ram #(.DEPTH(OAM_BYTES), .WIDTH(8)) u_oam (
        .i_clk   (i_clk),
        .i_we    (oam_we || (r_state == ST_CLEAR)),
        .i_waddr ((r_state == ST_CLEAR) ? r_clr_cnt[OAM_AW-1:0] : r_oam_ptr),
        .i_wdata ((r_state == ST_CLEAR) ? 8'h00 : r_wdata),
        .i_re    (accept),
        .i_raddr (r_oam_ptr),
        .o_rdata (oam_rdata)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_nmi;

endmodule
